@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PDAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PDAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pdar_pkg.sv @@
// shared types and constants of the pelco-d address remap relay
package pdar_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    localparam logic REQ_RX    = 1'b0;
    localparam logic REQ_TABLE = 1'b1;

    typedef struct packed {
        logic       valid;
        logic       bank;
        logic [7:0] addr;
        logic       in_range;
    } frame_start_t;

endpackage

@@ hw/rtl/pelco_d_address_remap_relay.sv @@
// top level of the pelco-d address remap relay
//
// s_* carries received serial bytes (s_tuser = 0) and translation table
// writes (s_tuser = 1); m_* carries the rebuilt frames, one byte per
// transaction, m_tlast on the checksum byte.
// hunting drops bytes until 0xFF; the next FRAME_LENGTH-1 bytes are taken
// as they come, the received checksum is dropped and a full frame goes out.
// s_tready is high but for the checksum stall below. after the checksum
// byte is taken, the output register is loaded with the sync byte, then
// the mapped address, then each command or option byte (one frame memory
// read each) and the checksum last. the address is looked up in the table
// memory on the cycle the checksum byte is taken, so later table writes do
// not touch a frame already complete.
// assembly of the next frame runs while one is sent (two memory banks); a
// checksum byte that would finish a second frame waits with s_tready low
// until the sender is idle. a stalled receiver holds the output register.
// reset returns to hunting; the table memory is not cleared and must be
// loaded before traffic.
module pelco_d_address_remap_relay #(
    parameter int MAP_DEPTH    = 256,
    parameter int FRAME_LENGTH = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte[7:0], table_index[15:8], table_value[23:16]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte[7:0]
    output logic        m_tlast    // frame_end
);

    import pdar_pkg::*;

    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int DATA_CNT   = FRAME_LENGTH - 3;
    localparam int DATA_DEPTH = (DATA_CNT > 0) ? DATA_CNT : 1;
    localparam int IDX_W      = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int POS_W      = $clog2(FRAME_LENGTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0] ADDR_POS = POS_W'(1);
    localparam logic [POS_W-1:0] DATA_POS = POS_W'(2);

    logic [7:0]       rx_byte;
    logic [7:0]       table_index;
    logic [7:0]       table_value;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       addr_reg;
    logic             wr_bank_reg;
    logic             accept;
    logic             rx_acc;
    logic             busy;
    logic             frame_done;
    logic             data_wr;
    logic [POS_W-1:0] wr_off;
    logic             map_wr;
    logic [IDX_W:0]   frame_rd_addr;
    logic [7:0]       frame_rd_q;
    logic [7:0]       map_q;
    frame_start_t     start;

    assign rx_byte     = s_tdata[7:0];
    assign table_index = s_tdata[15:8];
    assign table_value = s_tdata[23:16];

    assign s_tready   = !(busy && (pos_reg == LAST_POS));
    assign accept     = s_tvalid && s_tready;
    assign rx_acc     = accept && (s_tuser == REQ_RX);
    assign frame_done = rx_acc && (pos_reg == LAST_POS);
    assign data_wr    = rx_acc && (pos_reg >= DATA_POS) && (pos_reg != LAST_POS);
    assign wr_off     = pos_reg - DATA_POS;
    assign map_wr     = accept && (s_tuser == REQ_TABLE)
                        && ({1'b0, table_index} < 9'(MAP_DEPTH));

    always_comb
    begin
        pos_next = pos_reg;
        if (rx_acc)
        begin
            if (pos_reg == '0)
            begin
                if (rx_byte == SYNC_BYTE)
                begin
                    pos_next = ADDR_POS;
                end
            end
            else if (pos_reg == LAST_POS)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wr_bank_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (frame_done)
            begin
                wr_bank_reg <= !wr_bank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_acc && (pos_reg == ADDR_POS))
        begin
            addr_reg <= rx_byte;
        end
    end

    always_comb
    begin
        start.valid    = frame_done;
        start.bank     = wr_bank_reg;
        start.addr     = addr_reg;
        start.in_range = ({1'b0, addr_reg} < 9'(MAP_DEPTH));
    end

    pdar_map_ram #(
        .DEPTH (MAP_DEPTH),
        .AW    (MAP_AW)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr),
        .wr_addr (table_index[MAP_AW-1:0]),
        .wr_data (table_value),
        .rd_en   (frame_done),
        .rd_addr (addr_reg[MAP_AW-1:0]),
        .rd_data (map_q)
    );

    pdar_frame_ram #(
        .AW (IDX_W)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (data_wr),
        .wr_addr ({wr_bank_reg, wr_off[IDX_W-1:0]}),
        .wr_data (rx_byte),
        .rd_addr (frame_rd_addr),
        .rd_data (frame_rd_q)
    );

    pdar_emitter #(
        .FRAME_LENGTH (FRAME_LENGTH),
        .IDX_W        (IDX_W)
    ) u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .map_q    (map_q),
        .rd_addr  (frame_rd_addr),
        .rd_q     (frame_rd_q),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/pdar_map_ram.sv @@
// address translation memory, one write port and one registered read port
module pdar_map_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/pdar_frame_ram.sv @@
// two-bank frame payload memory for command and option bytes
module pdar_frame_ram #(
    parameter int AW = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW:0]   wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW:0]   rd_addr,
    output logic [7:0]    rd_data
);

    localparam int DEPTH = 2 << AW;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/pdar_emitter.sv @@
// frame emitter: walks the stored frame and drives the output register
module pdar_emitter #(
    parameter int FRAME_LENGTH = 7,
    parameter int IDX_W        = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdar_pkg::frame_start_t start,
    input  logic [7:0]            map_q,
    output logic [IDX_W:0]        rd_addr,
    input  logic [7:0]            rd_q,
    output logic                  busy,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // tx_byte[7:0]
    output logic                  m_tlast
);

    import pdar_pkg::*;

    localparam int DATA_CNT = FRAME_LENGTH - 3;
    localparam int DATA_DEPTH = (DATA_CNT > 0) ? DATA_CNT : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_DEPTH - 1);

    typedef enum logic [2:0] {
        E_IDLE,
        E_SYNC,
        E_ADDR,
        E_WAIT,
        E_DATA,
        E_SUM
    } emit_state_t;

    emit_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             bank_reg, bank_next;
    logic [7:0]       addr_reg, addr_next;
    logic             in_range_reg, in_range_next;
    logic [7:0]       sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic             load_ok;
    logic [7:0]       mapped;

    assign load_ok = !out_valid_reg || m_tready;
    assign mapped  = in_range_reg ? map_q : addr_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        bank_next      = bank_reg;
        addr_next      = addr_reg;
        in_range_next  = in_range_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (start.valid)
                begin
                    bank_next     = start.bank;
                    addr_next     = start.addr;
                    in_range_next = start.in_range;
                    state_next    = E_SYNC;
                end
            end
            E_SYNC:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = SYNC_BYTE;
                    out_last_next  = 1'b0;
                    state_next     = E_ADDR;
                end
            end
            E_ADDR:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mapped;
                    out_last_next  = 1'b0;
                    sum_next       = mapped;
                    idx_next       = '0;
                    state_next     = (DATA_CNT > 0) ? E_WAIT : E_SUM;
                end
            end
            E_WAIT:
            begin
                state_next = E_DATA;
            end
            E_DATA:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_q;
                    out_last_next  = 1'b0;
                    sum_next       = sum_reg + rd_q;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = E_SUM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = E_WAIT;
                    end
                end
            end
            E_SUM:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum_reg;
                    out_last_next  = 1'b1;
                    state_next     = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        bank_reg     <= bank_next;
        addr_reg     <= addr_next;
        in_range_reg <= in_range_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign rd_addr  = {bank_reg, idx_reg};
    assign busy     = (state_reg != E_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/pdar_checker.sv @@
// port-level checks of the relay and their bind to the top level
`include "assert_macros.svh"

module pdar_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,   // tx_byte[7:0]
    input logic        m_tlast    // frame_end
);

    import pdar_pkg::*;

    logic out_xfer;
    logic out_stall;
    logic last_xfer;
    logic sync_out;

    assign out_xfer  = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign last_xfer = out_xfer && m_tlast;
    assign sync_out  = (m_tdata == SYNC_BYTE) && !m_tlast;

    `PDAR_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid, "output transaction dropped while stalled")
    `PDAR_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_tdata) && $stable(m_tlast), "stall change")
    `PDAR_ASSERT_NEXT(a_no_double_last, last_xfer, !last_xfer, "two frame ends in a row")
    `PDAR_ASSERT_NEXT(a_sync_after_last, last_xfer, !m_tvalid || sync_out, "frame without sync")

endmodule

bind pelco_d_address_remap_relay pdar_checker u_pdar_checker (.*);
